// File: rtl/nsht_pkg.sv
// shared widths, codes, beat types and helpers of the nearest segment hit test
package nsht_pkg;

    localparam int COORD_BITS   = 16;
    localparam int MAX_SEGMENTS = 1024;
    localparam int RADIUS_W     = 10;
    localparam int RADIUS_RESET = 10;
    localparam int IDX_OUT_W    = 10;

    // coordinate differences and their magnitudes
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int LEN_W  = SQ_W + 1;
    localparam int DOT_W  = LEN_W + 1;
    localparam int DIST_W = LEN_W;

    // serial multiplier: LEN_W x MAG_W, one digit a cycle
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = MAG_W / DIGIT_W;
    localparam int MUL_CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
    localparam int MUL_SUM_W = LEN_W + DIGIT_W;
    localparam int PROD_W    = LEN_W + MAG_W;

    // serial divider: one quotient bit a cycle
    localparam int QUO_W     = MAG_W;
    localparam int DEN_W     = LEN_W + 1;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // segment numbering
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = $clog2(MAX_SEGMENTS);

    localparam logic CMD_BEGIN   = 1'b0;
    localparam logic CMD_SEGMENT = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic                          last_segment;
    } nsht_in_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_OUT_W-1:0]  segment_index;
        logic [DIST_W-1:0]     distance_squared;
    } nsht_out_t;

    function automatic logic [DIFF_W-1:0] nsht_sext(input logic [COORD_BITS-1:0] c);
        return {c[COORD_BITS-1], c};
    endfunction

    // magnitude of a difference, always below 2**MAG_W
    function automatic logic [MAG_W-1:0] nsht_abs(input logic [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] n;
        n = v[DIFF_W-1] ? (~v + 1'b1) : v;
        return n[MAG_W-1:0];
    endfunction

endpackage

// File: rtl/nsht_mul.sv
// digit-serial unsigned multiplier, one multiplier digit per cycle
module nsht_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [nsht_pkg::LEN_W-1:0]  a,
    input  logic [nsht_pkg::MAG_W-1:0]  b,
    output logic                        done,
    output logic [nsht_pkg::PROD_W-1:0] product
);
    import nsht_pkg::*;

    logic [LEN_W-1:0]     a_reg;
    logic [LEN_W-1:0]     hi_reg;
    logic [MAG_W-1:0]     lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [MUL_SUM_W-1:0] part;
    logic [MUL_SUM_W-1:0] sum;

    // partial product of one digit, added into the upper half
    assign part = MUL_SUM_W'(a_reg) * MUL_SUM_W'(lo_reg[DIGIT_W-1:0]);
    assign sum  = MUL_SUM_W'(hi_reg) + part;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[MUL_SUM_W-1:DIGIT_W];
            lo_reg <= {sum[DIGIT_W-1:0], lo_reg[MAG_W-1:DIGIT_W]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// File: rtl/nsht_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module nsht_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nsht_pkg::NUM_W-1:0] num,
    input  logic [nsht_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [nsht_pkg::QUO_W-1:0] quotient
);
    import nsht_pkg::*;

    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QUO_W-1:0]     nsh_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_reg, nsh_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper numerator bits start below the divisor, as the quotient fits QUO_W
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_W-1:QUO_W];
            nsh_reg <= num[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nsh_reg <= {nsh_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/nearest_segment_hit_test_core.sv
// top level of the nearest segment hit test: sequencer, state and beat ports
//
// usage
//   s_ channel: one beat per item. a begin beat (command 0) stores the query
//   point and loads the running best with pick_radius squared; each segment
//   beat (command 1) carries two endpoints and is tested against the point.
//   the beat with last_segment set closes the query and yields one m_ beat
//   holding hit, segment_index and distance_squared (zeros when no hit).
//   cfg_ channel: one beat writes pick_radius; always ready, write it only
//   while the block is idle.
// segment sequence
//   begin beat: handled in idle. segment beat: states len, dot, decide
//   and dist when the projection clamps to an endpoint, plus proj and div
//   when it lands inside the segment. a last beat adds the emit state to
//   load the output register. the work is done by two 4-bit digit-serial
//   multipliers (x, y lanes) and two bit-serial dividers (16-bit quotient).
// reset and stalls
//   aresetn (synchronous, active low) clears the query state and sets
//   pick_radius to 10. a waiting result sits in the output register while
//   the next beats are taken; only a further result waits for it to go.
module nearest_segment_hit_test_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  nsht_pkg::nsht_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output nsht_pkg::nsht_out_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nsht_pkg::RADIUS_W-1:0]  cfg_data
);
    import nsht_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEN    = 3'd1;
    localparam logic [2:0] S_DOT    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_PROJ   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DIST   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // sequencer
    logic [2:0] state_reg, state_next;
    logic       mul_start_reg, mul_start_next;
    logic       div_start_reg, div_start_next;

    // query state
    logic [RADIUS_W-1:0]   radius_reg;
    logic [COORD_BITS-1:0] query_x_reg, query_y_reg;
    logic [DIST_W-1:0]     best_dist_reg;
    logic [IDX_W-1:0]      best_index_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      seg_count_reg;

    // per segment working registers
    logic                  last_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [DIFF_W-1:0]     vx_reg, vy_reg, px_reg, py_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [DOT_W-1:0]      dot_reg;
    logic [COORD_BITS-1:0] jx_reg, jy_reg;

    // output register
    logic      m_valid_reg;
    nsht_out_t out_reg;

    logic accept, seg_accept, begin_accept, out_free;

    // lane operands and results
    logic [LEN_W-1:0]  mx_a, my_a;
    logic [MAG_W-1:0]  mx_b, my_b;
    logic              mx_done, my_done;
    logic [PROD_W-1:0] mx_prod, my_prod;
    logic [NUM_W-1:0]  num_x, num_y;
    logic [DEN_W-1:0]  den;
    logic              dx_done, dy_done;
    logic [QUO_W-1:0]  qx, qy;

    logic [MAG_W-1:0]      vx_mag, vy_mag, px_mag, py_mag, dx_mag, dy_mag;
    logic [DIFF_W-1:0]     dx, dy;
    logic [LEN_W-1:0]      len_sum;
    logic [DOT_W-1:0]      tx, ty, dot_sum;
    logic [DIST_W-1:0]     dist_sum;
    logic                  clamp_start, clamp_end;
    logic [COORD_BITS-1:0] jx_div, jy_div;
    logic [IDX_W-1:0]      idx_cur;
    logic [2*RADIUS_W-1:0] radius_sq;

    assign accept       = s_valid && s_ready;
    assign seg_accept   = accept && (s_data.command == CMD_SEGMENT);
    assign begin_accept = accept && (s_data.command == CMD_BEGIN);
    assign out_free     = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign vx_mag = nsht_abs(vx_reg);
    assign vy_mag = nsht_abs(vy_reg);
    assign px_mag = nsht_abs(px_reg);
    assign py_mag = nsht_abs(py_reg);
    assign dx     = nsht_sext(query_x_reg) - nsht_sext(jx_reg);
    assign dy     = nsht_sext(query_y_reg) - nsht_sext(jy_reg);
    assign dx_mag = nsht_abs(dx);
    assign dy_mag = nsht_abs(dy);

    // operands of both lanes follow the phase
    always_comb begin
        mx_a = '0;
        mx_b = '0;
        my_a = '0;
        my_b = '0;
        case (state_reg)
            S_LEN: begin
                mx_a = LEN_W'(vx_mag);
                mx_b = vx_mag;
                my_a = LEN_W'(vy_mag);
                my_b = vy_mag;
            end
            S_DOT: begin
                mx_a = LEN_W'(px_mag);
                mx_b = vx_mag;
                my_a = LEN_W'(py_mag);
                my_b = vy_mag;
            end
            S_PROJ: begin
                // dot is known positive and below len here
                mx_a = dot_reg[LEN_W-1:0];
                mx_b = vx_mag;
                my_a = dot_reg[LEN_W-1:0];
                my_b = vy_mag;
            end
            S_DIST: begin
                mx_a = LEN_W'(dx_mag);
                mx_b = dx_mag;
                my_a = LEN_W'(dy_mag);
                my_b = dy_mag;
            end
            default: begin
                mx_a = '0;
                mx_b = '0;
                my_a = '0;
                my_b = '0;
            end
        endcase
    end

    nsht_mul u_mul_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mx_a),
        .b       (mx_b),
        .done    (mx_done),
        .product (mx_prod)
    );

    nsht_mul u_mul_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (my_a),
        .b       (my_b),
        .done    (my_done),
        .product (my_prod)
    );

    // squared length, signed dot product, squared distance
    assign len_sum  = {1'b0, mx_prod[SQ_W-1:0]} + {1'b0, my_prod[SQ_W-1:0]};
    assign tx       = (px_reg[DIFF_W-1] ^ vx_reg[DIFF_W-1])
                    ? (~DOT_W'(mx_prod[SQ_W-1:0]) + 1'b1) : DOT_W'(mx_prod[SQ_W-1:0]);
    assign ty       = (py_reg[DIFF_W-1] ^ vy_reg[DIFF_W-1])
                    ? (~DOT_W'(my_prod[SQ_W-1:0]) + 1'b1) : DOT_W'(my_prod[SQ_W-1:0]);
    assign dot_sum  = tx + ty;
    assign dist_sum = {1'b0, mx_prod[SQ_W-1:0]} + {1'b0, my_prod[SQ_W-1:0]};

    // t at or below 0 (or a point segment) keeps the start, t at or above 1 the end
    assign clamp_start = (len_reg == '0) || dot_reg[DOT_W-1] || (dot_reg == '0);
    assign clamp_end   = (dot_reg[LEN_W-1:0] >= len_reg);

    // round half up: 2*dot*|v| + len over 2*len, len - 1 for a negative vector
    assign num_x = NUM_W'({mx_prod, 1'b0})
                 + NUM_W'(vx_reg[DIFF_W-1] ? (len_reg - 1'b1) : len_reg);
    assign num_y = NUM_W'({my_prod, 1'b0})
                 + NUM_W'(vy_reg[DIFF_W-1] ? (len_reg - 1'b1) : len_reg);
    assign den   = {len_reg, 1'b0};

    nsht_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .num      (num_x),
        .den      (den),
        .done     (dx_done),
        .quotient (qx)
    );

    nsht_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .num      (num_y),
        .den      (den),
        .done     (dy_done),
        .quotient (qy)
    );

    assign jx_div = sx_reg + (vx_reg[DIFF_W-1] ? (~COORD_BITS'(qx) + 1'b1) : COORD_BITS'(qx));
    assign jy_div = sy_reg + (vy_reg[DIFF_W-1] ? (~COORD_BITS'(qy) + 1'b1) : COORD_BITS'(qy));

    // segments past the last slot share its index
    assign idx_cur   = (seg_count_reg < CNT_W'(MAX_SEGMENTS))
                     ? seg_count_reg[IDX_W-1:0] : IDX_W'(MAX_SEGMENTS - 1);
    assign radius_sq = (2*RADIUS_W)'(radius_reg) * (2*RADIUS_W)'(radius_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        mul_start_next = 1'b0;
        div_start_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (seg_accept) begin
                    state_next     = S_LEN;
                    mul_start_next = 1'b1;
                end else if (begin_accept) begin
                    state_next = s_data.last_segment ? S_EMIT : S_IDLE;
                end
            end
            S_LEN: begin
                if (mx_done) begin
                    state_next     = S_DOT;
                    mul_start_next = 1'b1;
                end
            end
            S_DOT: begin
                if (mx_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next     = (clamp_start || clamp_end) ? S_DIST : S_PROJ;
                mul_start_next = 1'b1;
            end
            S_PROJ: begin
                if (mx_done) begin
                    state_next     = S_DIV;
                    div_start_next = 1'b1;
                end
            end
            S_DIV: begin
                if (dx_done) begin
                    state_next     = S_DIST;
                    mul_start_next = 1'b1;
                end
            end
            S_DIST: begin
                if (mx_done) begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and query state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            radius_reg     <= RADIUS_W'(RADIUS_RESET);
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            best_dist_reg  <= '0;
            best_index_reg <= '0;
            found_reg      <= 1'b0;
            seg_count_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;

            if (cfg_valid && cfg_ready) begin
                radius_reg <= cfg_data;
            end

            if (begin_accept) begin
                query_x_reg    <= s_data.point_x;
                query_y_reg    <= s_data.point_y;
                best_dist_reg  <= DIST_W'(radius_sq);
                best_index_reg <= '0;
                found_reg      <= 1'b0;
                seg_count_reg  <= '0;
            end

            // strictly closer only, so the first minimum is kept
            if (state_reg == S_DIST && mx_done) begin
                if (dist_sum < best_dist_reg) begin
                    best_dist_reg  <= dist_sum;
                    best_index_reg <= idx_cur;
                    found_reg      <= 1'b1;
                end
                if (seg_count_reg < CNT_W'(MAX_SEGMENTS)) begin
                    seg_count_reg <= seg_count_reg + 1'b1;
                end
            end

            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and result beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_data.last_segment;
        end
        if (seg_accept) begin
            sx_reg <= s_data.start_x;
            sy_reg <= s_data.start_y;
            ex_reg <= s_data.end_x;
            ey_reg <= s_data.end_y;
            vx_reg <= nsht_sext(s_data.end_x) - nsht_sext(s_data.start_x);
            vy_reg <= nsht_sext(s_data.end_y) - nsht_sext(s_data.start_y);
            px_reg <= nsht_sext(query_x_reg) - nsht_sext(s_data.start_x);
            py_reg <= nsht_sext(query_y_reg) - nsht_sext(s_data.start_y);
        end
        if (state_reg == S_LEN && mx_done) begin
            len_reg <= len_sum;
        end
        if (state_reg == S_DOT && mx_done) begin
            dot_reg <= dot_sum;
        end
        if (state_reg == S_DECIDE) begin
            jx_reg <= (!clamp_start && clamp_end) ? ex_reg : sx_reg;
            jy_reg <= (!clamp_start && clamp_end) ? ey_reg : sy_reg;
        end
        if (state_reg == S_DIV && dx_done) begin
            jx_reg <= jx_div;
            jy_reg <= jy_div;
        end
        if (state_reg == S_EMIT && out_free) begin
            out_reg.hit              <= found_reg;
            out_reg.segment_index    <= found_reg ? IDX_OUT_W'(best_index_reg) : '0;
            out_reg.distance_squared <= found_reg ? best_dist_reg : '0;
        end
    end

`ifndef SYNTHESIS
    // both lanes run in lock step
    a_lanes_together: assert property (@(posedge aclk) disable iff (!aresetn)
        (mx_done == my_done) && (dx_done == dy_done))
        else $error("x and y lanes out of step");

    a_div_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    a_segment_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == CMD_SEGMENT) |=> !s_ready)
        else $error("segment beat did not start the sequencer");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_EMIT))
        else $error("result beat raised outside the emit state");
`endif

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the nearest segment hit test core
module tb_top;
    import nsht_pkg::*;

    // run limits: cycle budget before the run is declared hung, and the quiet
    // time left for a segment still being processed once all picks are back
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_MAX    = 10;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    nsht_in_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    nsht_out_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data  = '0;

    // shadow of the block's query state, kept in step with accepted beats
    logic [RADIUS_W-1:0]   radius_setting = RADIUS_W'(RADIUS_RESET);
    logic signed [15:0]    probe_x        = '0;
    logic signed [15:0]    probe_y        = '0;
    longint unsigned       best_dist_sq   = 0;
    int                    best_seg       = 0;
    logic                  have_hit       = 1'b0;
    int                    seg_count      = 0;

    nsht_out_t             pending_picks[$];
    nsht_out_t             want;
    int                    pick_errors    = 0;
    int                    idle_pct       = 20;
    int                    cycle_count    = 0;

    nearest_segment_hit_test_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hang guard: a correct run finishes far inside this budget
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // round half up (towards +infinity) of dot * v / len, with 0 < dot < len
    function automatic longint round_share(input longint dot, input longint v,
                                           input longint len);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        if (v < 0) begin
            // negative vector: half-way cases round towards zero in magnitude
            q = (2 * dot * mag + len - 1) / (2 * len);
            return -longint'(q);
        end
        q = (2 * dot * mag + len) / (2 * len);
        return longint'(q);
    endfunction

    // squared distance from the query point to its projection on the segment
    function automatic longint unsigned segment_dist_sq(
            input logic signed [15:0] sx, input logic signed [15:0] sy,
            input logic signed [15:0] ex, input logic signed [15:0] ey);
        longint vx, vy, px, py, len, dot, jx, jy, dx, dy;
        vx  = longint'(ex) - longint'(sx);
        vy  = longint'(ey) - longint'(sy);
        px  = longint'(probe_x) - longint'(sx);
        py  = longint'(probe_y) - longint'(sy);
        len = vx * vx + vy * vy;
        dot = px * vx + py * vy;
        // zero length or t <= 0 both land on the start point
        jx  = sx;
        jy  = sy;
        if (len != 0 && dot > 0) begin
            if (dot >= len) begin
                // t clamped at one
                jx = ex;
                jy = ey;
            end else begin
                jx = sx + round_share(dot, vx, len);
                jy = sy + round_share(dot, vy, len);
            end
        end
        dx = longint'(probe_x) - jx;
        dy = longint'(probe_y) - jy;
        return longint'(dx * dx + dy * dy);
    endfunction

    // apply one accepted beat to the shadow state; a last beat queues a pick
    function automatic void track_nearest(input nsht_in_t it);
        longint unsigned d;
        int              slot;
        nsht_out_t       pick;
        if (it.command == CMD_BEGIN) begin
            probe_x      = it.point_x;
            probe_y      = it.point_y;
            best_dist_sq = longint'(radius_setting) * longint'(radius_setting);
            best_seg     = 0;
            have_hit     = 1'b0;
            seg_count    = 0;
        end else begin
            d    = segment_dist_sq(it.start_x, it.start_y, it.end_x, it.end_y);
            // once the count saturates every later segment shares the top index
            slot = (seg_count < MAX_SEGMENTS) ? seg_count : MAX_SEGMENTS - 1;
            // strictly less: on a tie the earlier segment keeps the pick
            if (d < best_dist_sq) begin
                best_dist_sq = d;
                best_seg     = slot;
                have_hit     = 1'b1;
            end
            if (seg_count < MAX_SEGMENTS)
                seg_count++;
        end
        if (it.last_segment) begin
            pick.hit              = have_hit;
            pick.segment_index    = have_hit ? IDX_OUT_W'(best_seg) : '0;
            pick.distance_squared = have_hit ? DIST_W'(best_dist_sq) : '0;
            pending_picks.push_back(pick);
        end
    endfunction

    // ------------------------------------------------------------------
    // result checker: every m_ beat is matched against the oldest pick
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        // receiver back-pressure follows the same idling rate as the sender
        m_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                pick_errors++;
                if (pick_errors <= REPORT_MAX)
                    $display("unexpected pick beat: hit %0b index %0d dist %0d",
                             m_data.hit, m_data.segment_index, m_data.distance_squared);
            end else begin
                want = pending_picks.pop_front();
                if (m_data.hit !== want.hit ||
                        m_data.segment_index !== want.segment_index ||
                        m_data.distance_squared !== want.distance_squared) begin
                    pick_errors++;
                    if (pick_errors <= REPORT_MAX)
                        $display("pick mismatch: expected hit %0b index %0d dist %0d, %s",
                                 want.hit, want.segment_index, want.distance_squared,
                                 $sformatf("got hit %0b index %0d dist %0d", m_data.hit,
                                           m_data.segment_index, m_data.distance_squared));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // beat builders and coordinate sources
    // ------------------------------------------------------------------

    // full-range coordinate, now and then one of the corner values
    function automatic logic [15:0] any_coord();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // coordinate scattered around a centre; wraps at the 16-bit edges
    function automatic logic [15:0] scatter(input int centre, input int spread);
        int c;
        c = centre + int'($urandom_range(2 * spread)) - spread;
        return c[15:0];
    endfunction

    // begin beat; the segment fields carry junk the block must ignore
    function automatic nsht_in_t make_begin(input logic [15:0] x, input logic [15:0] y,
                                            input logic last);
        nsht_in_t it;
        it.command      = CMD_BEGIN;
        it.point_x      = x;
        it.point_y      = y;
        it.start_x      = 16'($urandom_range(65535));
        it.start_y      = 16'($urandom_range(65535));
        it.end_x        = 16'($urandom_range(65535));
        it.end_y        = 16'($urandom_range(65535));
        it.last_segment = last;
        return it;
    endfunction

    // segment beat; the point fields carry junk the block must ignore
    function automatic nsht_in_t make_segment(input logic [15:0] sx, input logic [15:0] sy,
                                              input logic [15:0] ex, input logic [15:0] ey,
                                              input logic last);
        nsht_in_t it;
        it.command      = CMD_SEGMENT;
        it.point_x      = 16'($urandom_range(65535));
        it.point_y      = 16'($urandom_range(65535));
        it.start_x      = sx;
        it.start_y      = sy;
        it.end_x        = ex;
        it.end_y        = ey;
        it.last_segment = last;
        return it;
    endfunction

    // random segment around the query point: near ones give hits and ties,
    // straddling ones put the projection inside and exercise the divider
    function automatic nsht_in_t random_segment(input logic [15:0] px, input logic [15:0] py,
                                                input logic last);
        int          spread;
        int          pick;
        logic [15:0] sx, sy;
        spread = int'(radius_setting) + 8;
        pick   = $urandom_range(99);
        if (pick < 55) begin
            return make_segment(scatter($signed(px), spread), scatter($signed(py), spread),
                                scatter($signed(px), spread), scatter($signed(py), spread),
                                last);
        end
        if (pick < 85) begin
            sx = scatter($signed(px), 4096);
            sy = scatter($signed(py), 4096);
            return make_segment(sx, sy,
                                scatter(2 * $signed(px) - $signed(sx), spread / 2 + 3),
                                scatter(2 * $signed(py) - $signed(sy), spread / 2 + 3),
                                last);
        end
        return make_segment(any_coord(), any_coord(), any_coord(), any_coord(), last);
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // offer one beat, with random gaps; valid stays up after acceptance so a
    // back-to-back beat never lowers and raises it in the same step
    task automatic send_item(input nsht_in_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        track_nearest(it);
    endtask

    // wait for every outstanding pick, then let a trailing segment drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; only called with the block idle
    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid      <= 1'b0;
        radius_setting  = r;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight out of reset: the best distance is zero, so a stray segment
    // picks nothing, and a begin beat marked last closes an empty query
    task automatic test_reset_state();
        send_item(make_segment(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        send_item(make_begin(16'd100, 16'd100, 1'b1));
        settle();
    endtask

    // projection cases at the reset radius of ten, origin as query point
    task automatic test_geometry();
        send_item(make_begin(16'd0, 16'd0, 1'b0));
        // zero-length segment projects to its start, distance 25
        send_item(make_segment(16'd3, 16'd4, 16'd3, 16'd4, 1'b0));
        // projection halfway along, distance 4
        send_item(make_segment(-16'sd5, 16'd2, 16'd5, 16'd2, 1'b0));
        // t below zero clamps to the start, distance 2
        send_item(make_segment(16'd1, 16'd1, 16'd10, 16'd10, 1'b0));
        // t above one clamps to the end; equal distance, earlier pick stays
        send_item(make_segment(-16'sd10, -16'sd10, -16'sd1, -16'sd1, 1'b0));
        // half-way rounding upwards on a rising vector, distance 1
        send_item(make_segment(16'd0, -16'sd1, 16'd1, 16'd0, 1'b0));
        // half-way rounding towards +infinity on a falling vector, distance 1
        send_item(make_segment(16'd0, 16'd1, -16'sd1, 16'd0, 1'b0));
        // full-span diagonal through the origin, distance 0
        send_item(make_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b1));
        // beats after a last beat carry on with the same query
        send_item(make_segment(16'd2, 16'd0, 16'd2, 16'd0, 1'b0));
        send_item(make_segment(16'd0, 16'd1, 16'd0, 16'd1, 1'b1));
        settle();
    endtask

    // corner coordinates and the radius extremes
    task automatic test_register_extremes();
        write_radius(RADIUS_W'(1023));
        send_item(make_begin(16'h7fff, 16'h8000, 1'b0));
        // largest possible distance, far outside any radius
        send_item(make_segment(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0));
        send_item(make_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1));
        send_item(make_begin(16'h8000, 16'h8000, 1'b0));
        send_item(make_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b1));
        settle();
        // radius zero: nothing is strictly closer, not even a point on the line
        write_radius('0);
        send_item(make_begin(16'd5, 16'd5, 1'b0));
        send_item(make_segment(16'd5, 16'd5, 16'd5, 16'd5, 1'b1));
        settle();
    endtask

    // one query longer than the segment counter; the winners start at the last
    // slot and so all carry the top index
    task automatic test_index_saturation();
        logic [15:0] px, py;
        int          total;
        write_radius(RADIUS_W'(1023));
        idle_pct = 0;
        px    = scatter(0, 1000);
        py    = scatter(0, 1000);
        total = MAX_SEGMENTS + 6;
        send_item(make_begin(px, py, 1'b0));
        for (int k = 0; k < total; k++) begin
            if (k < MAX_SEGMENTS - 1)
                // at least 500 away along x: distance squared of 250000 or more
                send_item(make_segment(scatter($signed(px) + 750, 250),
                                       scatter($signed(py), 1000),
                                       scatter($signed(px) + 750, 250),
                                       scatter($signed(py), 1000), 1'b0));
            else
                send_item(make_segment(scatter($signed(px), 20), scatter($signed(py), 20),
                                       scatter($signed(px), 20), scatter($signed(py), 20),
                                       k == total - 1));
        end
        settle();
        idle_pct = 20;
    endtask

    // random queries over several radius settings; mostly well-formed
    // queries, the rest empty queries, stray segments and arbitrary beats
    task automatic test_random_queries();
        logic [15:0] px, py;
        nsht_in_t    it;
        int          sent, n, kind;
        px = '0;
        py = '0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       write_radius('0);
                1:       write_radius(RADIUS_W'(1023));
                2:       write_radius(RADIUS_W'(1));
                3:       write_radius(RADIUS_W'($urandom_range(1022, 2)));
                default: write_radius(RADIUS_W'(RADIUS_RESET));
            endcase
            sent = 0;
            while (sent < 130) begin
                kind = $urandom_range(99);
                if (kind < 75) begin
                    px = any_coord();
                    py = any_coord();
                    n  = $urandom_range(10, 1);
                    send_item(make_begin(px, py, 1'b0));
                    for (int k = 0; k < n; k++)
                        send_item(random_segment(px, py, k == n - 1));
                    sent += n + 1;
                end else if (kind < 85) begin
                    send_item(make_begin(any_coord(), any_coord(), 1'b1));
                    sent++;
                end else if (kind < 95) begin
                    // segments outside a fresh query, against whatever state is left
                    n = $urandom_range(3, 1);
                    for (int k = 0; k < n; k++)
                        send_item(random_segment(px, py, 1'($urandom_range(1))));
                    sent += n;
                end else begin
                    it         = make_segment(any_coord(), any_coord(), any_coord(),
                                              any_coord(), 1'($urandom_range(1)));
                    it.command = 1'($urandom_range(1));
                    send_item(it);
                    sent++;
                end
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_geometry();
        test_register_extremes();
        test_index_saturation();
        test_random_queries();
        settle();
        if (pick_errors == 0 && pending_picks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/nsht_pkg.sv
rtl/nsht_mul.sv
rtl/nsht_div.sv
rtl/nearest_segment_hit_test_core.sv
tb/sv/tb_top.sv
